@@ hdl/pbu_pkg.sv @@
// Package for the packed 4bpp bitmap unpacker.
// Holds field widths, configuration register indexes and the shared struct types.
// No dependencies.
package pbu_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned DimW     = 16;
  localparam int unsigned ColW     = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] PixTransparent = 8'hFF;
  localparam logic [ByteW-1:0] PixOpaqueZero  = 8'h00;
  localparam logic [ColW-1:0]  PadNibbles     = 17'd4;

  localparam logic [DimW-1:0]  ResetWidth  = 16'd16;
  localparam logic [DimW-1:0]  ResetHeight = 16'd16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH      = 3'd0,
    REG_IMAGE_HEIGHT     = 3'd1,
    REG_PALETTE_BASE     = 3'd2,
    REG_TRANSPARENT_MODE = 3'd3,
    REG_PADDING_MODE     = 3'd4
  } cfg_reg_e;

  // One result word.
  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             row_end;
    logic             image_end;
    logic             run_last;
  } pixel_t;

  // Position status of the byte at the input, from the counter block.
  typedef struct packed {
    logic skip;         // stored row is empty: byte is dropped, counters hold
    logic v0;           // high nibble is a visible pixel
    logic v1;           // low nibble is a visible pixel
    logic re0;          // high nibble ends the visible row
    logic re1;          // low nibble ends the visible row
    logic at_last_row;  // current row is the last one of the image
  } pos_t;

endpackage

@@ hdl/pbu_pos.sv @@
// Column and row position tracking for the packed 4bpp bitmap unpacker.
// Depends on pbu_pkg.
module pbu_pos (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pbu_pkg::DimW-1:0] width_i,
  input  logic [pbu_pkg::DimW-1:0] height_i,
  input  logic                     pad_i,
  input  logic                     advance_i,
  output pbu_pkg::pos_t            pos_o
);
  import pbu_pkg::*;

  logic [ColW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;

  logic [ColW-1:0] vis;
  logic [ColW-1:0] stored;
  logic [ColW-1:0] x, x_p1, x_p2;
  logic [DimW-1:0] last_row;
  logic            at_last;
  logic            wraps;
  logic            skip;

  // Odd widths are rounded down to even.
  assign vis    = {1'b0, width_i[DimW-1:1], 1'b0};
  assign stored = vis + (pad_i ? PadNibbles : '0);
  assign skip   = (stored == '0);

  // A stale column beyond the stored row restarts the row.
  assign x    = (col_q >= stored) ? '0 : col_q;
  assign x_p1 = x + ColW'(1);
  assign x_p2 = x + ColW'(2);

  // Zero height wraps to the largest row index, i.e. 65536 rows.
  assign last_row = height_i - DimW'(1);
  assign at_last  = (row_q >= last_row);
  assign wraps    = (x_p2 >= stored);

  assign pos_o.skip        = skip;
  assign pos_o.v0          = (x < vis);
  assign pos_o.v1          = (x_p1 < vis);
  assign pos_o.re0         = (x_p1 == vis);
  assign pos_o.re1         = (x_p2 == vis);
  assign pos_o.at_last_row = at_last;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i && !skip) begin
      if (wraps) begin
        col_d = '0;
        row_d = at_last ? '0 : row_q + DimW'(1);
      end else begin
        col_d = x_p2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ hdl/packed_4bpp_bitmap_unpacker.sv @@
// Top level of the packed 4bpp bitmap unpacker: configuration registers,
// nibble mapping, pixel pair buffer and output register.
// Depends on pbu_pkg and pbu_pos.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o / packed_byte_i) takes one packed
//   byte per word, high nibble being the left pixel. The output channel
//   (out_valid_o / out_stall_i and the pixel fields) delivers one palette index
//   per word, with row_end_o, image_end_o and run_last_o marking the last
//   visible pixel of a row, of the image, and of the pixels of one byte.
//   A byte gives zero, one or two pixels; padding nibbles and bytes that fall
//   entirely in the padding area produce nothing.
//   A byte is registered into the pair buffer at the edge that accepts it, and
//   its first pixel moves from there into the output register once that
//   register is free. The output register emits one pixel per cycle while the
//   receiver does not stall, so a byte with two visible pixels occupies it for
//   both of them; bytes that yield no pixel are taken every cycle. The byte is
//   decoded in the accept cycle into a two-entry pair buffer, which is refilled
//   in the same cycle its last entry moves out. Reset clears the column and row
//   counters, empties both buffers and loads the default configuration (16 x 16
//   pixels, base 0, both modes off). When the receiver stalls, the output word
//   holds; once the pair buffer is also occupied, in_stall_o rises and input
//   stops until the output drains. Configuration registers are written through
//   cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only while the block
//   is idle, which the block does not enforce. Unknown indexes are ignored.
module packed_4bpp_bitmap_unpacker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [pbu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbu_pkg::CfgDataW-1:0] cfg_data_i,
  // byte input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pbu_pkg::ByteW-1:0]    packed_byte_i,
  // pixel output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pbu_pkg::ByteW-1:0]    pixel_value_o,
  output logic                         row_end_o,
  output logic                         image_end_o,
  output logic                         run_last_o
);
  import pbu_pkg::*;

  // Configuration registers.
  logic [DimW-1:0]  width_q;
  logic [DimW-1:0]  height_q;
  logic [ByteW-1:0] base_q;
  logic             transp_q;
  logic             pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      base_q   <= '0;
      transp_q <= 1'b0;
      pad_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:      width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT:     height_q <= cfg_data_i;
        REG_PALETTE_BASE:     base_q   <= cfg_data_i[ByteW-1:0];
        REG_TRANSPARENT_MODE: transp_q <= cfg_data_i[0];
        REG_PADDING_MODE:     pad_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A zero nibble is either transparent or color 0; anything else is offset
  // by the palette base, wrapping at 256.
  function automatic logic [ByteW-1:0] map_nibble(logic [3:0] nib,
                                                  logic [ByteW-1:0] base,
                                                  logic transp);
    logic [ByteW-1:0] res;
    if (nib == 4'd0) begin
      res = transp ? PixTransparent : PixOpaqueZero;
    end else begin
      res = {4'd0, nib} + base;
    end
    return res;
  endfunction

  // Handshake state.
  logic       out_valid_q, out_valid_d;
  pixel_t     out_q, out_d;
  pixel_t     pair_q [2];
  pixel_t     pair_d [2];
  logic [1:0] cnt_q, cnt_d;

  logic   out_free;
  logic   pop;
  logic   accept;
  pos_t   pos;
  pixel_t new0, new1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = out_free && (cnt_q != 2'd0);
  // Input is taken only if the pair buffer is empty after this cycle's move.
  assign in_stall_o = (cnt_q == 2'd2) || ((cnt_q == 2'd1) && !out_free);
  assign accept     = in_valid_i && !in_stall_o;

  pbu_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_q),
    .height_i (height_q),
    .pad_i    (pad_q),
    .advance_i(accept),
    .pos_o    (pos)
  );

  always_comb begin
    new0.value     = map_nibble(packed_byte_i[7:4], base_q, transp_q);
    new0.row_end   = pos.re0;
    new0.image_end = pos.re0 && pos.at_last_row;
    new0.run_last  = !pos.v1;
    new1.value     = map_nibble(packed_byte_i[3:0], base_q, transp_q);
    new1.row_end   = pos.re1;
    new1.image_end = pos.re1 && pos.at_last_row;
    new1.run_last  = 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pair_d[0]   = pair_q[0];
    pair_d[1]   = pair_q[1];
    cnt_d       = cnt_q;

    if (pop) begin
      out_valid_d = 1'b1;
      out_d       = pair_q[0];
      pair_d[0]   = pair_q[1];
      cnt_d       = cnt_q - 2'd1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      pair_d[0] = new0;
      pair_d[1] = new1;
      if (pos.v1) begin
        cnt_d = 2'd2;
      end else if (pos.v0) begin
        cnt_d = 2'd1;
      end else begin
        cnt_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    pair_q[0] <= pair_d[0];
    pair_q[1] <= pair_d[1];
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_q.value;
  assign row_end_o     = out_q.row_end;
  assign image_end_o   = out_q.image_end;
  assign run_last_o    = out_q.run_last;

endmodule

@@ hdl/pbu_checker.sv @@
// Port-level assertions for the packed 4bpp bitmap unpacker, bound to the top.
// Depends on pbu_pkg and packed_4bpp_bitmap_unpacker.
module pbu_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [pbu_pkg::ByteW-1:0] pixel_value_o,
  input logic                      row_end_o,
  input logic                      image_end_o,
  input logic                      run_last_o
);
  import pbu_pkg::*;

  // The image ends only on a row end.
  a_image_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_end_o |-> row_end_o)
    else $error("image_end without row_end");

  // The first pixel of a pair is followed at once by the second, which closes the run.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o && run_last_o)
    else $error("second pixel of a byte did not follow");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_value_o) && $stable(row_end_o)
      && $stable(image_end_o) && $stable(run_last_o))
    else $error("output payload changed under stall");

endmodule

bind packed_4bpp_bitmap_unpacker pbu_checker u_pbu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pixel_value_o(pixel_value_o),
  .row_end_o    (row_end_o),
  .image_end_o  (image_end_o),
  .run_last_o   (run_last_o)
);

@@ dv/tb_packed_4bpp_bitmap_unpacker.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the packed 4bpp bitmap unpacker: directed table, then random phases.
// Depends on pbu_pkg and the packed_4bpp_bitmap_unpacker top level.
module tb_packed_4bpp_bitmap_unpacker;
  import pbu_pkg::*;

  // An index outside the register map, used to check that such writes are ignored.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  // Marks a directed row whose expected pixels come from the predictor.
  localparam int PredictRow = -1;
  // Cycles to let pass after the last expected pixel, so that bytes which give no
  // pixel have left the two-stage pipe before the block counts as idle.
  localparam int SettleCycles = 6;
  localparam int NumPhases = 16;
  localparam int BytesPerPhase = 125;
  // The phase and the byte within it where the sender waits for the output to drain.
  localparam int DrainPhase = 6;
  localparam int DrainByte = 60;

  typedef enum logic {
    STIM_WRITE,
    STIM_BYTE
  } stim_kind_e;

  // One row of the directed table: a register write or a byte. For bytes,
  // typed_n gives the number of typed pixels, or PredictRow.
  typedef struct {
    stim_kind_e        kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] data;
    int                typed_n;
    pixel_t            typed0;
    pixel_t            typed1;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    packed_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [ByteW-1:0]    pixel_value_o;
  logic                row_end_o;
  logic                image_end_o;
  logic                run_last_o;

  packed_4bpp_bitmap_unpacker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .packed_byte_i (packed_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o),
    .row_end_o     (row_end_o),
    .image_end_o   (image_end_o),
    .run_last_o    (run_last_o)
  );

  // Shadow copy of the configuration and of the position counters.
  logic [DimW-1:0]  width_q;
  logic [DimW-1:0]  height_q;
  logic [ByteW-1:0] base_q;
  logic             transparent_q;
  logic             padding_q;
  logic [ColW-1:0]  column_q;
  logic [DimW-1:0]  row_q;

  pixel_t    pending_pixels[$];
  stim_row_t directed_rows[$];

  // 0: no idling, 1: sender idles on 83 of 100 draws, 2: receiver stalls on 83 of 100,
  // 3: both sides on 22 of 100 draws.
  int idle_mode = 0;
  int errors = 0;
  int bytes_sent = 0;
  int pixels_seen = 0;
  int settings_run = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("packed_4bpp_bitmap_unpacker regression: fail");
    $finish;
  end

  function automatic logic sender_idles();
    case (idle_mode)
      1: return $urandom_range(99) < 83;
      3: return $urandom_range(99) < 22;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      2: return $urandom_range(99) < 83;
      3: return $urandom_range(99) < 22;
      default: return 1'b0;
    endcase
  endfunction

  // Palette index for one nibble: zero is either transparent or plain zero, any
  // other value is offset by the palette base and wraps at 256.
  function automatic logic [ByteW-1:0] nibble_to_index(input logic [3:0] nib);
    if (nib == 4'h0) begin
      return transparent_q ? PixTransparent : PixOpaqueZero;
    end
    return {4'h0, nib} + base_q;
  endfunction

  // Pixels caused by one byte; advances the shadow counters the way the block does.
  function automatic int unpack_byte(input logic [ByteW-1:0] b, output pixel_t pix[2]);
    logic [ColW-1:0] visible;
    logic [ColW-1:0] stored;
    logic [DimW-1:0] last_row;
    logic [ColW-1:0] x;
    logic [ColW-1:0] p;
    logic [3:0]      nib;
    logic            at_last;
    logic            re;
    int              n;
    pix[0] = '0;
    pix[1] = '0;
    n = 0;
    // Bit 0 of the width is dropped, so an odd width counts as the even one below it.
    visible = {1'b0, width_q & 16'hFFFE};
    stored = visible + (padding_q ? PadNibbles : '0);
    // An empty stored row swallows the byte without moving the counters.
    if (stored == '0) begin
      return 0;
    end
    // A height of zero gives a last row of 65535, that is 65536 rows.
    last_row = height_q - 16'd1;
    // Counters left stale by a register change restart the row or stay on the last one.
    x = (column_q >= stored) ? '0 : column_q;
    at_last = row_q >= last_row;
    for (int k = 0; k < 2; k++) begin
      p = x + ColW'(k);
      nib = (k == 0) ? b[7:4] : b[3:0];
      // Padding nibbles and the whole row when only padding is stored emit nothing.
      if (p < visible) begin
        re = (p + 17'd1) == visible;
        pix[n] = '{value: nibble_to_index(nib), row_end: re,
                   image_end: re && at_last, run_last: 1'b0};
        n++;
      end
    end
    if (n > 0) begin
      pix[n-1].run_last = 1'b1;
    end
    if ((x + 17'd2) >= stored) begin
      column_q = '0;
      row_q = at_last ? '0 : row_q + 16'd1;
    end else begin
      column_q = x + 17'd2;
    end
    return n;
  endfunction

  function automatic pixel_t px(input logic [ByteW-1:0] v, input logic re, input logic ie,
                                input logic rl);
    return '{value: v, row_end: re, image_end: ie, run_last: rl};
  endfunction

  function automatic void add_write(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    directed_rows.push_back('{STIM_WRITE, idx, data, 0, '0, '0});
  endfunction

  function automatic void add_byte(input logic [ByteW-1:0] b, input int n, input pixel_t t0,
                                   input pixel_t t1);
    directed_rows.push_back('{STIM_BYTE, '0, {8'h00, b}, n, t0, t1});
  endfunction

  function automatic void add_predicted(input logic [ByteW-1:0] b);
    add_byte(b, PredictRow, '0, '0);
  endfunction

  // Waits until every expected pixel is out, then lets the pipe settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the enable is lowered by whatever drives the next cycle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH:      width_q = data;
      REG_IMAGE_HEIGHT:     height_q = data;
      REG_PALETTE_BASE:     base_q = data[ByteW-1:0];
      REG_TRANSPARENT_MODE: transparent_q = data[0];
      REG_PADDING_MODE:     padding_q = data[0];
      default: ;
    endcase
  endtask

  // Offers one byte, with random idle cycles ahead of it, and records what it
  // should produce once the block takes it. Typed pixels, where given, replace
  // the predicted ones; the shadow counters move either way.
  task automatic send_byte(input logic [ByteW-1:0] b, input int typed_n, input pixel_t t0,
                           input pixel_t t1);
    pixel_t calc[2];
    int     n;
    cfg_we_i <= 1'b0;
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    packed_byte_i <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    n = unpack_byte(b, calc);
    if (typed_n == PredictRow) begin
      for (int i = 0; i < n; i++) begin
        pending_pixels.push_back(calc[i]);
      end
    end else begin
      if (typed_n > 0) pending_pixels.push_back(t0);
      if (typed_n > 1) pending_pixels.push_back(t1);
    end
    bytes_sent++;
  endtask

  function automatic void check_field(input string fname, input logic [ByteW-1:0] want,
                                      input logic [ByteW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %02h, got %02h", $time, fname, want, got);
      errors++;
    end
  endfunction

  // Output monitor: every accepted word is compared with the oldest expected pixel.
  // The stall is redrawn each cycle, so stalls land on any phase of the output.
  always @(posedge clk_i) begin : monitor
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: unexpected word: pixel %02h row_end %b image_end %b run_last %b",
                 $time, pixel_value_o, row_end_o, image_end_o, run_last_o);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_value", want.value, pixel_value_o);
        check_field("row_end", {7'h0, want.row_end}, {7'h0, row_end_o});
        check_field("image_end", {7'h0, want.image_end}, {7'h0, image_end_o});
        check_field("run_last", {7'h0, want.run_last}, {7'h0, run_last_o});
      end
      pixels_seen++;
    end
    out_stall_i <= receiver_stalls();
  end

  initial begin : stimulus
    logic [CfgDataW-1:0] w;
    logic [CfgDataW-1:0] h;
    int                  r;

    width_q = ResetWidth;
    height_q = ResetHeight;
    base_q = '0;
    transparent_q = 1'b0;
    padding_q = 1'b0;
    column_q = '0;
    row_q = '0;

    // Directed table. Rows with typed pixels are read straight off the rules;
    // the rest go through the predictor.
    // Reset configuration: 16 x 16, base 0, no transparency, no padding.
    add_byte(8'h00, 2, px(8'h00, 0, 0, 0), px(8'h00, 0, 0, 1));
    add_byte(8'hFF, 2, px(8'h0F, 0, 0, 0), px(8'h0F, 0, 0, 1));
    // A write to an unmapped index must leave everything as it was.
    add_write(RegUnused, 16'hFFFF);
    add_byte(8'h1F, 2, px(8'h01, 0, 0, 0), px(8'h0F, 0, 0, 1));
    // Narrowest image, one row, base wrapping around, zero as transparent.
    add_write(REG_IMAGE_WIDTH, 16'd2);
    add_write(REG_IMAGE_HEIGHT, 16'd1);
    add_write(REG_PALETTE_BASE, 16'h00FF);
    add_write(REG_TRANSPARENT_MODE, 16'd1);
    add_byte(8'h01, 2, px(8'hFF, 0, 0, 0), px(8'h00, 1, 1, 1));
    add_byte(8'hF0, 2, px(8'h0E, 0, 0, 0), px(8'hFF, 1, 1, 1));
    // Padding: the two bytes after the visible pair are swallowed.
    add_write(REG_PADDING_MODE, 16'd1);
    add_byte(8'h23, 2, px(8'h01, 0, 0, 0), px(8'h02, 1, 1, 1));
    add_byte(8'h45, 0, '0, '0);
    add_byte(8'h67, 0, '0, '0);
    // Empty stored row: bytes are dropped outright.
    add_write(REG_IMAGE_WIDTH, 16'd0);
    add_write(REG_PADDING_MODE, 16'd0);
    add_byte(8'hAB, 0, '0, '0);
    // Zero visible width with padding: counters move, nothing comes out.
    add_write(REG_PADDING_MODE, 16'd1);
    add_byte(8'hCD, 0, '0, '0);
    // Widest odd width and zero height, which mean 65534 pixels and 65536 rows.
    add_write(REG_IMAGE_WIDTH, 16'hFFFF);
    add_write(REG_IMAGE_HEIGHT, 16'd0);
    add_write(REG_PALETTE_BASE, 16'h0080);
    add_write(REG_TRANSPARENT_MODE, 16'd0);
    add_write(REG_PADDING_MODE, 16'd0);
    add_byte(8'h00, 2, px(8'h00, 0, 0, 0), px(8'h00, 0, 0, 1));
    add_byte(8'h81, 2, px(8'h88, 0, 0, 0), px(8'h81, 0, 0, 1));
    // Odd width 3 taken as 2, two rows; the stale column restarts the row.
    add_write(REG_IMAGE_WIDTH, 16'd3);
    add_write(REG_IMAGE_HEIGHT, 16'd2);
    add_write(REG_PALETTE_BASE, 16'h0010);
    add_byte(8'h12, 2, px(8'h11, 0, 0, 0), px(8'h12, 1, 0, 1));
    add_byte(8'h34, 2, px(8'h13, 0, 0, 0), px(8'h14, 1, 1, 1));
    // Width 1 has no visible pixel and no padding: the byte is dropped.
    add_write(REG_IMAGE_WIDTH, 16'd1);
    add_predicted(8'h5A);
    // Padded rows of six pixels over three rows with transparency.
    add_write(REG_IMAGE_WIDTH, 16'd6);
    add_write(REG_IMAGE_HEIGHT, 16'd3);
    add_write(REG_TRANSPARENT_MODE, 16'd1);
    add_write(REG_PADDING_MODE, 16'd1);
    add_predicted(8'h09);
    add_predicted(8'h70);
    add_predicted(8'hE0);
    add_predicted(8'h0D);
    add_predicted(8'h3C);
    // Stale row count: run a few rows into a tall image, then shrink it.
    add_write(REG_IMAGE_WIDTH, 16'd2);
    add_write(REG_IMAGE_HEIGHT, 16'hFFFF);
    add_write(REG_PADDING_MODE, 16'd0);
    add_predicted(8'h11);
    add_predicted(8'h11);
    add_predicted(8'h11);
    add_write(REG_IMAGE_HEIGHT, 16'd2);
    add_predicted(8'h22);
    add_predicted(8'h33);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == STIM_WRITE) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_byte(directed_rows[i].data[ByteW-1:0], directed_rows[i].typed_n,
                  directed_rows[i].typed0, directed_rows[i].typed1);
      end
    end

    // Random phases. Sizes are mostly small so that rows and images wrap often;
    // now and then an extreme or a fully random value comes up. The counters
    // are never realigned, so stale positions carry over from phase to phase.
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      idle_mode = ph % 4;
      r = $urandom_range(99);
      if (r < 70) w = CfgDataW'($urandom_range(24));
      else if (r < 85) w = CfgDataW'($urandom_range(300, 25));
      else if (r < 93) w = ($urandom_range(2) == 0) ? 16'd2 : 16'hFFFE | 16'($urandom_range(1));
      else w = CfgDataW'($urandom_range(16'hFFFF));
      r = $urandom_range(99);
      if (r < 75) h = CfgDataW'($urandom_range(6, 1));
      else if (r < 85) h = 16'd0;
      else if (r < 92) h = 16'hFFFF;
      else h = CfgDataW'($urandom_range(16'hFFFF));
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      // Upper data bits are random too; the narrow registers must ignore them.
      write_reg(REG_PALETTE_BASE, CfgDataW'($urandom_range(16'hFFFF)));
      write_reg(REG_TRANSPARENT_MODE, CfgDataW'($urandom_range(16'hFFFF)));
      write_reg(REG_PADDING_MODE, CfgDataW'($urandom_range(16'hFFFF)));
      settings_run++;
      for (int k = 0; k < BytesPerPhase; k++) begin
        // Once in the run the sender holds off until the output has drained.
        if (ph == DrainPhase && k == DrainByte) begin
          wait_idle();
        end
        send_byte(ByteW'($urandom_range(255)), PredictRow, '0, '0);
      end
    end

    wait_idle();
    $display("Ran %0d bytes over the directed table and %0d random settings.",
             bytes_sent, settings_run);
    $display("Checked %0d pixel words, %0d mismatches.", pixels_seen, errors);
    if (errors == 0) begin
      $display("packed_4bpp_bitmap_unpacker regression: pass");
    end else begin
      $display("packed_4bpp_bitmap_unpacker regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pbu_pkg.sv
hdl/pbu_pos.sv
hdl/packed_4bpp_bitmap_unpacker.sv
hdl/pbu_checker.sv
dv/tb_packed_4bpp_bitmap_unpacker.sv
